// ----- rtl/core/cstf_pkg.sv -----
package cstf_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned NameW    = 64;
  localparam int unsigned NameBytes = NameW / CharW;
  localparam int unsigned MaxNames = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DepthW   = 8;
  localparam int unsigned LenW     = 4;

  localparam logic [CfgIdxW-1:0] CFG_IDX_MASK = 3'd6;

  localparam logic [CharW-1:0] CH_HASH  = 8'h23;
  localparam logic [CharW-1:0] CH_AT    = 8'h40;
  localparam logic [CharW-1:0] CH_BANG  = 8'h21;
  localparam logic [CharW-1:0] CH_UNDER = 8'h5F;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_NL    = 8'h0A;
  localparam logic [CharW-1:0] CH_LO_A  = 8'h61;
  localparam logic [CharW-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
  localparam logic [CharW-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CharW-1:0] CH_LO_I  = 8'h69;
  localparam logic [CharW-1:0] CH_LO_F  = 8'h66;
  localparam logic [CharW-1:0] CH_LO_E  = 8'h65;
  localparam logic [CharW-1:0] CH_LO_N  = 8'h6E;
  localparam logic [CharW-1:0] CH_LO_D  = 8'h64;
  localparam logic [CharW-1:0] CASE_GAP = 8'h20;

  localparam logic [NameW-1:0] BANG_KEY = {{(NameW - CharW){1'b0}}, CH_BANG};

  typedef enum logic [3:0] {
    M_IDLE,
    M_HASH,
    M_AT,
    M_I,
    M_IF,
    M_WORD,
    M_E,
    M_EN,
    M_END,
    M_ENDI,
    M_ENDIF
  } match_state_e;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] idx;
    logic [NameW-1:0]   data;
  } cfg_wr_t;

  function automatic logic is_letter(input logic [CharW-1:0] c, input logic [CharW-1:0] lower);
    return (c == lower) || (c == (lower - CASE_GAP));
  endfunction

endpackage

// ----- rtl/core/cstf_if.sv -----
interface cstf_in_if;
  logic                     valid;
  logic                     ready;
  logic [cstf_pkg::CharW-1:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

interface cstf_out_if;
  logic                     valid;
  logic                     ready;
  logic [cstf_pkg::CharW-1:0] out_char;

  modport source (output valid, output out_char, input ready);
  modport sink   (input valid, input out_char, output ready);
endinterface

// ----- rtl/core/cstf_cfg.sv -----
module cstf_cfg #(
  parameter int unsigned NUM_DEFINES = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cstf_pkg::cfg_wr_t          wr_i,
  input  logic [cstf_pkg::NameW-1:0] key_i,
  output logic                       found_o
);
  import cstf_pkg::*;

  logic [NameW-1:0]       names_q [NUM_DEFINES];
  logic [NUM_DEFINES-1:0] mask_q;
  logic [NUM_DEFINES-1:0] hit;

  for (genvar i = 0; i < NUM_DEFINES; i++) begin : g_name
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        names_q[i] <= '0;
      end else if (wr_i.we && (wr_i.idx == CfgIdxW'(i))) begin
        names_q[i] <= wr_i.data;
      end
    end

    assign hit[i] = mask_q[i] && (names_q[i] == key_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (wr_i.we && (wr_i.idx == CFG_IDX_MASK)) begin
      mask_q <= wr_i.data[NUM_DEFINES-1:0];
    end
  end

  assign found_o = |hit;

endmodule

// ----- rtl/core/cstf_match.sv -----
module cstf_match #(
  parameter int unsigned MAX_WORD_BYTES = 8,
  parameter int unsigned MAX_NEST       = 255
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [cstf_pkg::CharW-1:0] char_i,
  output logic [cstf_pkg::NameW-1:0] key_o,
  input  logic                       found_i,
  output logic                       emit_o
);
  import cstf_pkg::*;

  localparam logic [LenW-1:0]   WordMax = LenW'(MAX_WORD_BYTES);
  localparam logic [DepthW-1:0] NestMax = DepthW'(MAX_NEST);

  match_state_e      state_q, state_d;
  logic [NameW-1:0]  word_q, word_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              neg_q, neg_d;
  logic              ovf_q, ovf_d;
  logic [DepthW-1:0] depth_q, depth_d;

  logic              empty;
  logic              fail;
  logic [CharW-1:0]  folded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      word_q  <= '0;
      len_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      depth_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      word_q  <= word_d;
      len_q   <= len_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      depth_q <= depth_d;
    end
  end

  // A lone bang is tested as the one-byte word "!".
  assign key_o = (neg_q && (len_q == '0) && !ovf_q) ? BANG_KEY : word_q;
  assign empty = (len_q == '0) && !ovf_q && !neg_q;

  always_comb begin
    if (neg_q && ((len_q != '0) || ovf_q)) begin
      fail = !ovf_q && found_i;
    end else if (neg_q) begin
      fail = !found_i;
    end else if ((len_q != '0) || ovf_q) begin
      fail = ovf_q || !found_i;
    end else begin
      fail = 1'b0;
    end
  end

  always_comb begin
    state_d = M_IDLE;
    word_d  = word_q;
    len_d   = len_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    depth_d = depth_q;
    folded  = char_i;

    unique case (state_q)
      M_HASH:  state_d = (char_i == CH_AT) ? M_AT : M_IDLE;
      M_AT: begin
        if (is_letter(char_i, CH_LO_I)) begin
          state_d = M_I;
        end else if (is_letter(char_i, CH_LO_E)) begin
          state_d = M_E;
        end
      end
      M_I:     state_d = is_letter(char_i, CH_LO_F) ? M_IF : M_IDLE;
      M_IF:    state_d = (char_i == CH_SPACE) ? M_WORD : M_IDLE;
      M_WORD: begin
        state_d = M_WORD;
        if ((char_i >= CH_LO_A) && (char_i <= CH_LO_Z)) begin
          folded = char_i - CASE_GAP;
        end
        if (((char_i >= CH_LO_A) && (char_i <= CH_LO_Z)) ||
            ((char_i >= CH_UP_A) && (char_i <= CH_UP_Z)) || (char_i == CH_UNDER)) begin
          if (len_q >= WordMax) begin
            ovf_d = 1'b1;
          end else begin
            for (int i = 0; i < NameBytes; i++) begin
              if (len_q[LenW-2:0] == (LenW-1)'(i)) begin
                word_d[i*CharW +: CharW] = folded;
              end
            end
            len_d = len_q + LenW'(1);
          end
        end else if (empty && (char_i == CH_BANG)) begin
          neg_d = 1'b1;
        end else begin
          if (fail && (depth_q < NestMax)) begin
            depth_d = depth_q + DepthW'(1);
          end
          word_d  = '0;
          len_d   = '0;
          neg_d   = 1'b0;
          ovf_d   = 1'b0;
          state_d = M_IDLE;
        end
      end
      M_E:     state_d = is_letter(char_i, CH_LO_N) ? M_EN : M_IDLE;
      M_EN:    state_d = is_letter(char_i, CH_LO_D) ? M_END : M_IDLE;
      M_END:   state_d = is_letter(char_i, CH_LO_I) ? M_ENDI : M_IDLE;
      M_ENDI:  state_d = is_letter(char_i, CH_LO_F) ? M_ENDIF : M_IDLE;
      M_ENDIF: begin
        if (depth_q != '0) begin
          depth_d = depth_q - DepthW'(1);
        end
      end
      default: state_d = (char_i == CH_HASH) ? M_HASH : M_IDLE;
    endcase
  end

  assign emit_o = (depth_d == '0) || (char_i == CH_NL) || (char_i == CH_HASH);

  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= NestMax)
    else $error("skip depth above its limit");

  a_depth_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q != $past(depth_q)) |->
      ((depth_q == $past(depth_q) + DepthW'(1)) || (depth_q == $past(depth_q) - DepthW'(1))))
    else $error("skip depth moved by more than one");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= WordMax)
    else $error("word length above its limit");

  a_word_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != M_WORD) |-> (empty && (word_q == '0)))
    else $error("word not cleared outside the word state");

endmodule

// ----- rtl/core/conditional_section_text_filter.sv -----
// Channel  Dir  Beat
// in_i     in   in_char, one raw text byte
// out_o    out  out_char, the byte when it is passed on
// cfg      in   cfg_we_i / cfg_idx_i / cfg_data_i, one register write
//
// One byte is taken every cycle unless a stall on out_o holds a byte to be passed on.
// The throughput is set by the single matcher step between the input and result registers.
// Reset clears the matcher, the skip counter, the names and the enable mask.
// A stall on out_o holds the result register; bytes that produce no result still drain.
// The input register takes a new beat in the cycle its current byte moves on.
module conditional_section_text_filter #(
  parameter int unsigned MAX_WORD_BYTES = 8,
  parameter int unsigned NUM_DEFINES    = 6,
  parameter int unsigned MAX_NEST       = 255
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cstf_in_if.sink                      in_i,
  cstf_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [cstf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cstf_pkg::NameW-1:0]   cfg_data_i
);
  import cstf_pkg::*;

  logic             s1_valid_q, s1_valid_d;
  logic [CharW-1:0] s1_char_q;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q;

  logic             in_fire;
  logic             out_free;
  logic             s1_adv;
  logic             emit;
  logic             found;
  logic [NameW-1:0] key;
  cfg_wr_t          cfg_wr;

  assign cfg_wr = '{we: cfg_we_i, idx: cfg_idx_i, data: cfg_data_i};

  cstf_cfg #(
    .NUM_DEFINES(NUM_DEFINES)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_wr),
    .key_i  (key),
    .found_o(found)
  );

  cstf_match #(
    .MAX_WORD_BYTES(MAX_WORD_BYTES),
    .MAX_NEST      (MAX_NEST)
  ) u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .char_i (s1_char_q),
    .key_o  (key),
    .found_i(found),
    .emit_o (emit)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!emit || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= in_i.in_char;
    end
    if (s1_adv && emit) begin
      out_char_q <= s1_char_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && emit) |=> (out_valid_q && (out_char_q == $past(s1_char_q))))
    else $error("passed byte not loaded into the result register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !(s1_adv && emit))
    else $error("stalled result overwritten");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import cstf_pkg::*;

  localparam int unsigned WordMax = 8;
  localparam int unsigned NestMax = 255;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_PASS,
    CHK_DROP
  } row_check_e;

  typedef struct packed {
    logic [CharW-1:0] ch;
    row_check_e       how;
  } directed_row_t;

  localparam directed_row_t DirectedRows [25] = '{
    '{8'h00, CHK_PASS}, '{CH_HASH, CHK_PASS}, '{CH_AT, CHK_PASS}, '{CH_LO_I, CHK_PASS},
    '{"F", CHK_PASS}, '{CH_SPACE, CHK_PASS}, '{"f", CHK_PREDICT}, '{"o", CHK_PREDICT},
    '{CH_BANG, CHK_PREDICT},
    '{CH_HASH, CHK_PASS}, '{CH_AT, CHK_PASS}, '{"I", CHK_PASS}, '{CH_LO_F, CHK_PASS},
    '{CH_SPACE, CHK_PASS}, '{"Q", CHK_PREDICT}, '{CH_NL, CHK_PASS},
    '{8'hFF, CHK_DROP}, '{CH_HASH, CHK_PASS}, '{CH_AT, CHK_DROP}, '{CH_LO_E, CHK_DROP},
    '{"N", CHK_DROP}, '{"D", CHK_DROP}, '{"I", CHK_DROP}, '{"f", CHK_DROP},
    '{"x", CHK_PREDICT}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [NameW-1:0] cfg_data;

  cstf_in_if  in_ch ();
  cstf_out_if out_ch ();

  conditional_section_text_filter i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  logic [NameW-1:0] def_names [MaxNames];
  logic [MaxNames-1:0] def_mask;
  match_state_e m_state;
  logic [NameW-1:0] w_bytes;
  logic [LenW-1:0] w_len;
  logic w_neg;
  logic w_ovf;
  logic [DepthW-1:0] skip_lvl;

  logic [CharW-1:0] passed_bytes [$];
  logic [CharW-1:0] burst [$];
  logic [CharW-1:0] want;
  logic steady;
  int errors;
  int bytes_sent;
  int bytes_checked;
  int settings_used;
  int skip_peak;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(50_000_000);
    $display("Timeout: %0d beats still expected on the output", passed_bytes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t: MISMATCH %s", $realtime, what);
  endtask

  function automatic logic is_word_char(input logic [CharW-1:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) || c == CH_UNDER;
  endfunction

  function automatic logic keyword_hit(input logic [CharW-1:0] c, input logic [CharW-1:0] lower);
    return c == lower || c == lower - CASE_GAP;
  endfunction

  function automatic logic name_defined(input logic [NameW-1:0] key);
    for (int i = 0; i < MaxNames; i++) begin
      if (def_mask[i] && def_names[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void collect_word_byte(input logic [CharW-1:0] c);
    if (w_len >= WordMax) begin
      w_ovf = 1'b1;
    end else begin
      w_bytes[w_len*CharW +: CharW] = c;
      w_len++;
    end
  endfunction

  function automatic void test_word();
    logic fail;
    fail = 1'b0;
    if (w_neg && (w_len != 0 || w_ovf)) begin
      fail = !w_ovf && name_defined(w_bytes);
    end else if (w_neg) begin
      fail = !name_defined(BANG_KEY);
    end else if (w_len != 0 || w_ovf) begin
      fail = w_ovf || !name_defined(w_bytes);
    end
    if (fail && skip_lvl < NestMax) skip_lvl++;
    w_bytes = '0;
    w_len = '0;
    w_neg = 1'b0;
    w_ovf = 1'b0;
  endfunction

  // Advances the filter by one byte and tells whether the byte is passed on.
  function automatic logic filter_byte(input logic [CharW-1:0] c);
    logic bare;
    bare = w_len == 0 && !w_ovf && !w_neg;
    case (m_state)
      M_IDLE:  m_state = (c == CH_HASH) ? M_HASH : M_IDLE;
      M_HASH:  m_state = (c == CH_AT) ? M_AT : M_IDLE;
      M_AT:    m_state = keyword_hit(c, CH_LO_I) ? M_I :
                         keyword_hit(c, CH_LO_E) ? M_E : M_IDLE;
      M_I:     m_state = keyword_hit(c, CH_LO_F) ? M_IF : M_IDLE;
      M_IF:    m_state = (c == CH_SPACE) ? M_WORD : M_IDLE;
      M_WORD: begin
        if (c >= CH_LO_A && c <= CH_LO_Z) begin
          collect_word_byte(c - CASE_GAP);
        end else if (is_word_char(c)) begin
          collect_word_byte(c);
        end else if (bare && c == CH_BANG) begin
          w_neg = 1'b1;
        end else begin
          test_word();
          m_state = M_IDLE;
        end
      end
      M_E:     m_state = keyword_hit(c, CH_LO_N) ? M_EN : M_IDLE;
      M_EN:    m_state = keyword_hit(c, CH_LO_D) ? M_END : M_IDLE;
      M_END:   m_state = keyword_hit(c, CH_LO_I) ? M_ENDI : M_IDLE;
      M_ENDI:  m_state = keyword_hit(c, CH_LO_F) ? M_ENDIF : M_IDLE;
      M_ENDIF: begin
        m_state = M_IDLE;
        if (skip_lvl != 0) skip_lvl--;
      end
      default: m_state = (c == CH_HASH) ? M_HASH : M_IDLE;
    endcase
    return skip_lvl == 0 || c == CH_NL || c == CH_HASH;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 75) return $urandom_range(0, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic send_byte(input logic [CharW-1:0] b, input row_check_e how);
    int gap;
    logic pass;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_char <= b;
    do @(posedge clk); while (!in_ch.ready);
    pass = filter_byte(b);
    if (how == CHK_PASS) pass = 1'b1;
    else if (how == CHK_DROP) pass = 1'b0;
    if (pass) passed_bytes.push_back(b);
    bytes_sent++;
    if (int'(skip_lvl) > skip_peak) skip_peak = int'(skip_lvl);
  endtask

  task automatic send_burst();
    foreach (burst[k]) send_byte(burst[k], CHK_PREDICT);
    burst.delete();
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (passed_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [NameW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx < MaxNames) def_names[idx] = val;
    else if (idx == CFG_IDX_MASK) def_mask = val[MaxNames-1:0];
  endtask

  function automatic logic [CharW-1:0] word_char();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return CharW'(CH_UP_A + r);
    if (r < 52) return CharW'(CH_LO_A + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [CharW-1:0] any_case(input logic [CharW-1:0] lower);
    return $urandom_range(0, 1) ? lower : lower - CASE_GAP;
  endfunction

  function automatic logic [CharW-1:0] word_end(input logic bare);
    logic [CharW-1:0] c;
    do begin
      case ($urandom_range(0, 3))
        0: c = CH_SPACE;
        1: c = CH_NL;
        2: c = CH_HASH;
        default: c = CharW'($urandom_range(0, 255));
      endcase
    end while (is_word_char(c) || (bare && c == CH_BANG));
    return c;
  endfunction

  function automatic logic [NameW-1:0] pick_name();
    logic [NameW-1:0] v;
    int len;
    v = '0;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = BANG_KEY;
      3: v = {$urandom, $urandom};
      default: begin
        len = $urandom_range(1, NameBytes);
        for (int k = 0; k < len; k++) begin
          v[k*CharW +: CharW] = ($urandom_range(0, 26) == 0) ? CH_UNDER :
                                CharW'(CH_UP_A + $urandom_range(0, 25));
        end
      end
    endcase
    return v;
  endfunction

  function automatic void push_if_head();
    burst.push_back(CH_HASH);
    burst.push_back(CH_AT);
    burst.push_back(any_case(CH_LO_I));
    burst.push_back(any_case(CH_LO_F));
    burst.push_back(CH_SPACE);
  endfunction

  function automatic void push_if_test();
    logic [CharW-1:0] b;
    logic bare;
    int len;
    int nbytes;
    int r;
    int which;
    push_if_head();
    bare = 1'b1;
    nbytes = 0;
    if ($urandom_range(0, 3) == 0) begin
      burst.push_back(CH_BANG);
      bare = 1'b0;
    end
    if ($urandom_range(0, 1)) begin
      which = $urandom_range(0, MaxNames - 1);
      for (int k = 0; k < NameBytes; k++) begin
        b = def_names[which][k*CharW +: CharW];
        if (b == 0) break;
        if (b >= CH_UP_A && b <= CH_UP_Z && $urandom_range(0, 1)) b = b + CASE_GAP;
        burst.push_back(b);
        nbytes++;
      end
    end else begin
      r = $urandom_range(0, 19);
      len = (r == 0) ? 0 : (r < 4) ? $urandom_range(WordMax + 1, WordMax + 3) :
            $urandom_range(1, WordMax);
      for (int k = 0; k < len; k++) burst.push_back(word_char());
      nbytes = len;
    end
    if (nbytes > 0) bare = 1'b0;
    if (nbytes > 0 && $urandom_range(0, 9) == 0) burst.push_back(CH_BANG);
    burst.push_back(word_end(bare));
  endfunction

  function automatic void push_endif();
    burst.push_back(CH_HASH);
    burst.push_back(CH_AT);
    burst.push_back(any_case(CH_LO_E));
    burst.push_back(any_case(CH_LO_N));
    burst.push_back(any_case(CH_LO_D));
    burst.push_back(any_case(CH_LO_I));
    burst.push_back(any_case(CH_LO_F));
    burst.push_back(CharW'($urandom_range(0, 255)));
  endfunction

  function automatic void push_noise();
    int len;
    len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 5))
        0: burst.push_back(CH_HASH);
        1: burst.push_back(CH_AT);
        2: burst.push_back(CH_NL);
        default: burst.push_back(CharW'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  task automatic configure_phase(input int phase);
    for (int i = 0; i < MaxNames; i++) set_reg(CfgIdxW'(i), pick_name());
    if (phase == 0) set_reg(CFG_IDX_MASK, '0);
    else if (phase == 5) set_reg(CFG_IDX_MASK, NameW'({MaxNames{1'b1}}));
    else set_reg(CFG_IDX_MASK, NameW'($urandom_range(0, 63)));
    set_reg(CfgIdxSpare, {$urandom, $urandom});
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bytes_checked++;
      if (passed_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected out_char 0x%02h", out_ch.out_char));
      end else begin
        want = passed_bytes.pop_front();
        if (out_ch.out_char !== want) begin
          report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h", out_ch.out_char, want));
        end
      end
    end
  end

  initial begin
    int run;
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      run = $urandom_range(1, 24);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int phase_bytes;
    int pick;
    int cut;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.in_char <= '0;
    steady = 1'b0;
    errors = 0;
    bytes_sent = 0;
    bytes_checked = 0;
    settings_used = 0;
    skip_peak = 0;
    for (int i = 0; i < MaxNames; i++) def_names[i] = '0;
    def_mask = '0;
    m_state = M_IDLE;
    w_bytes = '0;
    w_len = '0;
    w_neg = 1'b0;
    w_ovf = 1'b0;
    skip_lvl = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_reg(CfgIdxW'(0), 64'h4F46);
    set_reg(CfgIdxW'(1), BANG_KEY);
    set_reg(CfgIdxW'(2), '1);
    set_reg(CfgIdxW'(3), 64'h4847_4645_4443_4241);
    set_reg(CfgIdxW'(4), '0);
    set_reg(CfgIdxW'(5), {{(NameW - CharW){1'b0}}, CH_UNDER});
    set_reg(CFG_IDX_MASK, NameW'({MaxNames{1'b1}}));
    set_reg(CfgIdxSpare, '1);
    settings_used++;
    foreach (DirectedRows[r]) send_byte(DirectedRows[r].ch, DirectedRows[r].how);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      configure_phase(phase);
      steady = (phase == 2);
      phase_bytes = 0;
      while (phase_bytes < 165) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          push_if_test();
        end else if (pick < 65) begin
          push_endif();
        end else if (pick < 75) begin
          if ($urandom_range(0, 1)) push_if_test();
          else push_endif();
          cut = $urandom_range(1, burst.size() - 1);
          while (burst.size() > cut) void'(burst.pop_back());
          burst.push_back(CharW'($urandom_range(0, 255)));
        end else begin
          push_noise();
        end
        phase_bytes += burst.size();
        send_burst();
      end
    end

    // With no name enabled every plain word fails, so a run of six if lines
    // nests the skip counter six levels before endif lines partly unwind it.
    drain();
    set_reg(CFG_IDX_MASK, '0);
    settings_used++;
    steady = 1'b0;
    for (int k = 0; k < 6; k++) begin
      push_if_head();
      burst.push_back(word_char());
      burst.push_back(word_end(1'b0));
      send_burst();
    end
    for (int k = 0; k < 3; k++) begin
      push_if_head();
      burst.push_back(word_char());
      burst.push_back(word_end(1'b0));
      push_endif();
      push_endif();
      send_burst();
    end
    drain();

    if (passed_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", passed_bytes.size()));
    end
    $display("Run covered %0d input beats under %0d register settings, %0d output beats checked.",
             bytes_sent, settings_used, bytes_checked);
    $display("The skip counter reached a depth of %0d.", skip_peak);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
